// ===== sv/bmp24_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared widths, header constants and register indexes for the 24-bit BMP
// pixel unpacker.
// ----------------------------------------------------------------------------
package bmp24_pkg;

    localparam int DIM_W   = 14;
    localparam int COORD_W = 15;
    localparam int COLOR_W = 24;
    localparam int BYTE_W  = 8;
    localparam int HALF_W  = 16;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 4;

    localparam logic [DIM_W-1:0]  MAX_DIMENSION = 14'd10000;
    localparam logic [HALF_W-1:0] BMP_SIGNATURE = 16'h4d42;
    localparam logic [HALF_W-1:0] BMP_DEPTH     = 16'd24;

    localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH   = 4'd0;
    localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT  = 4'd1;
    localparam logic [INDEX_W-1:0] REG_ORIGIN_X      = 4'd2;
    localparam logic [INDEX_W-1:0] REG_ORIGIN_Y      = 4'd3;
    localparam logic [INDEX_W-1:0] REG_TRANSPARENT   = 4'd4;
    localparam logic [INDEX_W-1:0] REG_SIGNATURE     = 4'd5;
    localparam logic [INDEX_W-1:0] REG_BITS_PER_PIX  = 4'd6;
    localparam logic [INDEX_W-1:0] REG_DATA_BYTES    = 4'd7;

    // byte position within a stored pixel
    localparam logic [1:0] PHASE_BLUE  = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_RED   = 2'd2;

endpackage

// ===== sv/bmp24_pixel_unpacker_unit.sv =====
// A pixel is registered when its red byte is taken, in the spare word if the port stalls.
// Throughput: one byte per cycle; a spare result register lets a new byte in while a
// result still waits to be taken, and the input stalls only when both are full or
// after each register write (and after reset), while the two-stage registered header
// check settles.
// Reset (aresetn low, synchronous) clears the settings, the counters and the result port.
// ----------------------------------------------------------------------------
// bmp24_pixel_unpacker_unit
// Unpacks the pixel array of a 24-bit bottom-up BMP image one byte per word, skips
// row padding, flips rows and emits one pixel write per pixel unless transparent black.
// ----------------------------------------------------------------------------
module bmp24_pixel_unpacker_unit
    import bmp24_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]  cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_pixel_byte,
    input  logic               s_frame_start,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_screen_x,
    output logic [COORD_W-1:0] m_screen_y,
    output logic [COLOR_W-1:0] m_color
);

    // configuration registers
    logic [DIM_W-1:0]  image_width_reg;
    logic [DIM_W-1:0]  image_height_reg;
    logic [DIM_W-1:0]  origin_x_reg;
    logic [DIM_W-1:0]  origin_y_reg;
    logic              transparent_reg;
    logic [HALF_W-1:0] signature_reg;
    logic [HALF_W-1:0] bpp_reg;
    logic [DATA_W-1:0] data_bytes_reg;

    // header check pipeline
    logic [1:0]        settle_reg;
    logic              basic_ok_reg;
    logic [29:0]       total_reg;
    logic              hdr_ok_reg;
    logic [HALF_W-1:0] stride_bytes;
    logic              basic_ok_next;

    // progress state
    logic [1:0]        phase_reg,   phase_next;
    logic [DIM_W-1:0]  column_reg,  column_next;
    logic [DIM_W-1:0]  row_reg,     row_next;
    logic [1:0]        pad_reg,     pad_next;
    logic [BYTE_W-1:0] blue_reg,    blue_next;
    logic [BYTE_W-1:0] green_reg,   green_next;
    logic              done_reg,    done_next;

    // frame start view of the state
    logic [1:0]        eff_phase;
    logic [DIM_W-1:0]  eff_column;
    logic [DIM_W-1:0]  eff_row;
    logic [1:0]        eff_pad;
    logic [BYTE_W-1:0] eff_blue;
    logic [BYTE_W-1:0] eff_green;
    logic              eff_done;

    logic [DIM_W-1:0]  row_inc;
    logic [DIM_W:0]    column_inc;
    logic [COLOR_W-1:0] color_word;
    logic              emit;

    logic               m_valid_reg;
    logic [COORD_W-1:0] screen_x_reg, screen_x_next;
    logic [COORD_W-1:0] screen_y_reg, screen_y_next;
    logic [COLOR_W-1:0] color_reg;

    // spare result word
    logic               skid_valid_reg;
    logic [COORD_W-1:0] skid_x_reg;
    logic [COORD_W-1:0] skid_y_reg;
    logic [COLOR_W-1:0] skid_color_reg;

    logic s_accept;
    logic result_push;
    logic main_hold;

    assign cfg_ready   = 1'b1;
    assign s_ready     = (settle_reg == 2'd0) && !skid_valid_reg;
    assign s_accept    = s_valid && s_ready;
    assign result_push = s_accept && emit;
    assign main_hold   = m_valid_reg && !m_ready;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= '0;
            image_height_reg <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            transparent_reg  <= 1'b0;
            signature_reg    <= '0;
            bpp_reg          <= '0;
            data_bytes_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data[DIM_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data[DIM_W-1:0];
                REG_TRANSPARENT:  transparent_reg  <= cfg_data[0];
                REG_SIGNATURE:    signature_reg    <= cfg_data[HALF_W-1:0];
                REG_BITS_PER_PIX: bpp_reg          <= cfg_data[HALF_W-1:0];
                REG_DATA_BYTES:   data_bytes_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // header check, two registered stages
    assign stride_bytes = ({2'b00, image_width_reg} * 16'd3 + 16'd3) & ~16'd3;

    assign basic_ok_next = (signature_reg == BMP_SIGNATURE) && (bpp_reg == BMP_DEPTH)
                        && (image_width_reg != '0) && (image_height_reg != '0)
                        && (image_width_reg <= MAX_DIMENSION)
                        && (image_height_reg <= MAX_DIMENSION);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg   <= 2'd2;
            basic_ok_reg <= 1'b0;
            hdr_ok_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                settle_reg <= 2'd2;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
            basic_ok_reg <= basic_ok_next;
            hdr_ok_reg   <= basic_ok_reg && ({2'b00, total_reg} <= data_bytes_reg);
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= {14'd0, stride_bytes} * {16'd0, image_height_reg};
    end

    // byte assembly, padding skip and counters
    always_comb begin
        eff_phase  = s_frame_start ? PHASE_BLUE : phase_reg;
        eff_column = s_frame_start ? '0 : column_reg;
        eff_row    = s_frame_start ? '0 : row_reg;
        eff_pad    = s_frame_start ? '0 : pad_reg;
        eff_blue   = s_frame_start ? '0 : blue_reg;
        eff_green  = s_frame_start ? '0 : green_reg;
        eff_done   = s_frame_start ? 1'b0 : done_reg;

        phase_next  = eff_phase;
        column_next = eff_column;
        row_next    = eff_row;
        pad_next    = eff_pad;
        blue_next   = eff_blue;
        green_next  = eff_green;
        done_next   = eff_done;
        emit        = 1'b0;

        row_inc    = eff_row + 1'b1;
        column_inc = {1'b0, eff_column} + 1'b1;
        color_word = {s_pixel_byte, eff_green, eff_blue};

        screen_x_next = {1'b0, origin_x_reg} + {1'b0, eff_column};
        screen_y_next = {1'b0, origin_y_reg} + {1'b0, image_height_reg} - 15'd1
                      - {1'b0, eff_row};

        if (hdr_ok_reg && !eff_done) begin
            if (eff_row >= image_height_reg) begin
                done_next = 1'b1;
            end else if (eff_pad != 2'd0) begin
                pad_next = eff_pad - 2'd1;
            end else if (eff_phase == PHASE_BLUE) begin
                blue_next  = s_pixel_byte;
                phase_next = PHASE_GREEN;
            end else if (eff_phase == PHASE_GREEN) begin
                green_next = s_pixel_byte;
                phase_next = PHASE_RED;
            end else begin
                phase_next = PHASE_BLUE;
                emit       = !(transparent_reg && (color_word == '0));
                if (column_inc >= {1'b0, image_width_reg}) begin
                    column_next = '0;
                    row_next    = row_inc;
                    pad_next    = image_width_reg[1:0];
                    done_next   = (row_inc >= image_height_reg);
                end else begin
                    column_next = column_inc[DIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PHASE_BLUE;
            column_reg <= '0;
            row_reg    <= '0;
            pad_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            done_reg   <= 1'b0;
        end else if (s_accept) begin
            phase_reg  <= phase_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            done_reg   <= done_next;
        end
    end

    // result register and spare word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (result_push) begin
            if (main_hold) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                screen_x_reg <= skid_x_reg;
                screen_y_reg <= skid_y_reg;
                color_reg    <= skid_color_reg;
            end
        end else if (result_push) begin
            if (main_hold) begin
                skid_x_reg     <= screen_x_next;
                skid_y_reg     <= screen_y_next;
                skid_color_reg <= color_word;
            end else begin
                screen_x_reg <= screen_x_next;
                screen_y_reg <= screen_y_next;
                color_reg    <= color_word;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_screen_x = screen_x_reg;
    assign m_screen_y = screen_y_reg;
    assign m_color    = color_reg;

endmodule

// ===== sv/bmp24_checker.sv =====
// ----------------------------------------------------------------------------
// bmp24_checker
// Port-level checks for the 24-bit BMP pixel unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module bmp24_checker
    import bmp24_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [COORD_W-1:0] m_screen_x,
    input logic [COORD_W-1:0] m_screen_y,
    input logic [COLOR_W-1:0] m_color
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_screen_x)
            && $stable(m_screen_y) && $stable(m_color))
        else $error("result word changed while stalled");

    // reset empties the result port
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input waits for the header check after a register write
    a_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken before header check settled");

    // a result port that was empty fills only from a word taken the cycle before
    a_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid) |-> $past(s_valid && s_ready))
        else $error("result without an input word");

endmodule

bind bmp24_pixel_unpacker_unit bmp24_checker u_bmp24_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 24-bit BMP pixel unpacker: byte words go in
// through a queued driver, pixel writes are predicted in the bench and
// compared field by field by a monitor, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import bmp24_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] pix;
        logic              fs;
    } byte_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
    } pixel_t;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index     = '0;
    logic [DATA_W-1:0]  cfg_data      = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_pixel_byte  = '0;
    logic               s_frame_start = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [COORD_W-1:0] m_screen_x;
    logic [COORD_W-1:0] m_screen_y;
    logic [COLOR_W-1:0] m_color;

    bmp24_pixel_unpacker_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_byte  (s_pixel_byte),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_screen_x    (m_screen_x),
        .m_screen_y    (m_screen_y),
        .m_color       (m_color)
    );

    // shadow registers
    logic [DIM_W-1:0]  reg_width       = '0;
    logic [DIM_W-1:0]  reg_height      = '0;
    logic [DIM_W-1:0]  reg_origin_x    = '0;
    logic [DIM_W-1:0]  reg_origin_y    = '0;
    logic              reg_transparent = 1'b0;
    logic [HALF_W-1:0] reg_signature   = '0;
    logic [HALF_W-1:0] reg_bpp         = '0;
    logic [DATA_W-1:0] reg_avail       = '0;

    // unpacking progress
    logic [1:0]        phase_now  = PHASE_BLUE;
    logic [DIM_W-1:0]  col_now    = '0;
    logic [DIM_W-1:0]  row_now    = '0;
    logic [1:0]        pad_now    = '0;
    logic [BYTE_W-1:0] blue_now   = '0;
    logic [BYTE_W-1:0] green_now  = '0;
    logic              frame_done = 1'b0;

    byte_word_t byte_queue[$];
    pixel_t     pixel_expect[$];

    int  mismatch_count    = 0;
    int  bytes_queued      = 0;
    int  rx_hold_requests  = 0;
    int  rx_hold_served    = 0;
    int  tx_wait           = 0;
    int  tx_quiet          = 0;
    int  rx_wait           = 0;
    int  rx_quiet          = 0;
    int  rx_long           = 0;
    logic in_taken         = 1'b0;
    logic out_taken        = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void apply_reg(input logic [INDEX_W-1:0] idx,
                                      input logic [DATA_W-1:0] val);
        case (idx)
            REG_IMAGE_WIDTH:  reg_width       = val[DIM_W-1:0];
            REG_IMAGE_HEIGHT: reg_height      = val[DIM_W-1:0];
            REG_ORIGIN_X:     reg_origin_x    = val[DIM_W-1:0];
            REG_ORIGIN_Y:     reg_origin_y    = val[DIM_W-1:0];
            REG_TRANSPARENT:  reg_transparent = val[0];
            REG_SIGNATURE:    reg_signature   = val[HALF_W-1:0];
            REG_BITS_PER_PIX: reg_bpp         = val[HALF_W-1:0];
            REG_DATA_BYTES:   reg_avail       = val;
            default: ;
        endcase
    endfunction

    function automatic void clear_progress();
        phase_now  = PHASE_BLUE;
        col_now    = '0;
        row_now    = '0;
        pad_now    = '0;
        blue_now   = '0;
        green_now  = '0;
        frame_done = 1'b0;
    endfunction

    function automatic bit header_valid();
        longint unsigned row_len;
        longint unsigned need;
        if (reg_signature != BMP_SIGNATURE || reg_bpp != BMP_DEPTH) return 1'b0;
        if (reg_width == '0 || reg_height == '0) return 1'b0;
        if (reg_width > MAX_DIMENSION || reg_height > MAX_DIMENSION) return 1'b0;
        row_len = reg_width;
        row_len = (row_len * 3 + 3) & ~64'd3;
        need = row_len * reg_height;
        return need <= reg_avail;
    endfunction

    // one byte word in, at most one pixel write out
    function automatic bit unpack_byte(input logic [BYTE_W-1:0] b, input logic fs,
                                       output pixel_t px);
        logic [DATA_W-1:0]  sum;
        logic [COLOR_W-1:0] c;
        px = '0;
        if (fs) clear_progress();
        if (!header_valid() || frame_done) return 1'b0;
        if (row_now >= reg_height) begin
            frame_done = 1'b1;
            return 1'b0;
        end
        if (pad_now != 2'd0) begin
            pad_now = pad_now - 2'd1;
            return 1'b0;
        end
        if (phase_now == PHASE_BLUE) begin
            blue_now  = b;
            phase_now = PHASE_GREEN;
            return 1'b0;
        end
        if (phase_now == PHASE_GREEN) begin
            green_now = b;
            phase_now = PHASE_RED;
            return 1'b0;
        end
        phase_now = PHASE_BLUE;
        c = {b, green_now, blue_now};
        unpack_byte = 1'b0;
        if (!(reg_transparent && c == '0)) begin
            sum = 32'(reg_origin_x) + 32'(col_now);
            px.x = sum[COORD_W-1:0];
            sum = 32'(reg_origin_y) + 32'(reg_height) - 32'd1 - 32'(row_now);
            px.y = sum[COORD_W-1:0];
            px.color = c;
            unpack_byte = 1'b1;
        end
        if (32'(col_now) + 32'd1 >= 32'(reg_width)) begin
            col_now = '0;
            row_now = row_now + 1'b1;
            pad_now = reg_width[1:0];
            if (row_now >= reg_height) frame_done = 1'b1;
        end else begin
            col_now = col_now + 1'b1;
        end
    endfunction

    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // handshake sampling, prediction and checking
    always @(posedge aclk) begin
        pixel_t px;
        pixel_t got;
        in_taken  <= aresetn && s_valid && s_ready;
        out_taken <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (m_valid && m_ready) begin
                got = '{x: m_screen_x, y: m_screen_y, color: m_color};
                if (pixel_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel write x=%0d y=%0d color=%06h",
                                              got.x, got.y, got.color));
                end else begin
                    px = pixel_expect.pop_front();
                    if (got.x != px.x)
                        report_mismatch($sformatf("screen_x %0d, want %0d", got.x, px.x));
                    if (got.y != px.y)
                        report_mismatch($sformatf("screen_y %0d, want %0d", got.y, px.y));
                    if (got.color != px.color)
                        report_mismatch($sformatf("color %06h, want %06h", got.color, px.color));
                end
            end
            if (s_valid && s_ready) begin
                if (unpack_byte(s_pixel_byte, s_frame_start, px)) pixel_expect.push_back(px);
            end
        end
    end

    // byte word driver
    always @(negedge aclk) begin
        byte_word_t w;
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    w = byte_queue.pop_front();
                    s_valid       <= 1'b1;
                    s_pixel_byte  <= w.pix;
                    s_frame_start <= w.fs;
                    tx_wait = draw_wait(tx_quiet);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rx_hold_served != rx_hold_requests) begin
                rx_hold_served++;
                rx_long = 400;
            end
            if (out_taken) rx_wait = draw_wait(rx_quiet);
            if (rx_long > 0) begin
                rx_long--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_word(input logic [BYTE_W-1:0] b, input logic fs);
        byte_queue.push_back('{pix: b, fs: fs});
        bytes_queued++;
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_header(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
                              input logic [DATA_W-1:0] ox, input logic [DATA_W-1:0] oy,
                              input logic [DATA_W-1:0] tr, input logic [DATA_W-1:0] sig,
                              input logic [DATA_W-1:0] bpp, input logic [DATA_W-1:0] avail);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_TRANSPARENT, tr);
        write_reg(REG_SIGNATURE, sig);
        write_reg(REG_BITS_PER_PIX, bpp);
        write_reg(REG_DATA_BYTES, avail);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every word is taken and every pixel write has come back
    task automatic drain();
        int guard;
        guard = 0;
        while ((byte_queue.size() != 0 || s_valid || pixel_expect.size() != 0)
               && guard < 50000) begin
            @(posedge aclk);
            guard++;
        end
        if (guard >= 50000) begin
            report_mismatch($sformatf("%0d pixel writes still outstanding",
                                      pixel_expect.size()));
            pixel_expect.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    function automatic int frame_bytes(input int w, input int h);
        return ((3 * w + 3) / 4) * 4 * h;
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return '1;
            3:       return 24'd1 << $urandom_range(0, COLOR_W - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_origin();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(0, 16383);
        endcase
    endfunction

    task automatic push_frame(input int w, input int h, input int cap,
                              input bit with_start, input bit noisy);
        int row_len;
        int total;
        int pos;
        logic [COLOR_W-1:0] c;
        logic [BYTE_W-1:0]  b;
        logic               fs;
        row_len = frame_bytes(w, 1);
        total = frame_bytes(w, h);
        if (total > cap) total = cap;
        c = '0;
        for (int i = 0; i < total; i++) begin
            pos = i % row_len;
            if (pos < 3 * w) begin
                if (pos % 3 == 0) c = pick_color();
                b = c[8 * (pos % 3) +: 8];
            end else begin
                b = $urandom_range(0, 255);
            end
            fs = (i == 0) ? with_start : (noisy && $urandom_range(0, 40) == 0);
            push_word(b, fs);
        end
    endtask

    initial begin
        int w;
        int h;
        int cap;
        int len;
        int kind;
        int frames;
        int phase_no;
        logic [DATA_W-1:0] ww;
        logic [DATA_W-1:0] hh;
        logic [DATA_W-1:0] ox;
        logic [DATA_W-1:0] oy;
        logic [DATA_W-1:0] tr;
        logic [DATA_W-1:0] sig;
        logic [DATA_W-1:0] bpp;
        logic [DATA_W-1:0] need;
        logic [DATA_W-1:0] avail;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // registers still at reset: header rejected
        push_word(8'hFF, 1'b1);
        push_word(8'h00, 1'b0);
        drain();

        // single pixel image, exact data size, then a word past the image
        set_header(1, 1, 0, 0, 0, BMP_SIGNATURE, BMP_DEPTH, 4);
        push_word(8'hFF, 1'b1);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hA5, 1'b0);
        drain();

        // data one byte short
        set_header(1, 1, 0, 0, 0, BMP_SIGNATURE, BMP_DEPTH, 3);
        push_word(8'h12, 1'b1);
        push_word(8'h34, 1'b0);
        push_word(8'h56, 1'b0);
        drain();

        // transparency, far origin, padding, restart mid image
        set_header(2, 2, 16383, 16383, 1, BMP_SIGNATURE, BMP_DEPTH, 16);
        push_word(8'h00, 1'b1);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h3C, 1'b0);
        push_word(8'hC3, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'h02, 1'b0);
        push_word(8'h03, 1'b0);
        push_word(8'h80, 1'b1);
        push_word(8'h40, 1'b0);
        push_word(8'h20, 1'b0);
        drain();

        // largest dimensions, partial image and restart
        set_header(MAX_DIMENSION, MAX_DIMENSION, 0, 0, 0, BMP_SIGNATURE, BMP_DEPTH, '1);
        push_frame(MAX_DIMENSION, MAX_DIMENSION, 3, 1'b1, 1'b0);
        push_frame(MAX_DIMENSION, MAX_DIMENSION, 3, 1'b1, 1'b0);

        phase_no = 0;
        while (bytes_queued < 1330) begin
            drain();
            kind = $urandom_range(0, 9);
            ox = pick_origin();
            oy = pick_origin();
            tr = $urandom_range(0, 1);
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 6);
            cap = 1 << 20;
            if (phase_no % 6 == 1) begin
                w = 8;
                h = 6;
                kind = 5;
            end
            if (kind == 1) begin
                w = $urandom_range(0, 1) ? int'(MAX_DIMENSION) : $urandom_range(1, 10000);
                h = $urandom_range(0, 1) ? int'(MAX_DIMENSION) : $urandom_range(1, 10000);
                cap = 40;
            end
            need = frame_bytes(w, h);
            avail = need + (($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 0);
            if (kind == 1 && $urandom_range(0, 1) == 1) avail = '1;
            sig = BMP_SIGNATURE;
            bpp = BMP_DEPTH;
            ww = w;
            hh = h;
            if (kind == 0) begin
                case ($urandom_range(0, 6))
                    0: sig = $urandom;
                    1: bpp = $urandom;
                    2: ww = 0;
                    3: hh = 0;
                    4: ww = $urandom_range(10001, 16383);
                    5: avail = need - 1;
                    default: begin
                        ww = $urandom;
                        hh = $urandom;
                        ox = $urandom;
                        oy = $urandom;
                        tr = $urandom;
                        sig = $urandom;
                        bpp = $urandom;
                        avail = $urandom;
                    end
                endcase
            end
            set_header(ww, hh, ox, oy, tr, sig, bpp, avail);
            if (phase_no % 6 == 1) rx_hold_requests++;
            frames = (phase_no % 5 == 2) ? 2 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                // sender waits for every pixel write before going on
                if (f == 1 && phase_no % 5 == 2) drain();
                len = cap;
                if ($urandom_range(0, 5) == 0) begin
                    len = $urandom_range(1, frame_bytes(w, h));
                    if (len > cap) len = cap;
                end
                push_frame(w, h, len, $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
                repeat ($urandom_range(0, 3)) push_word($urandom, 1'b0);
            end
            phase_no++;
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
